[rtl/core/ted_pkg.sv]
`default_nettype none

package ted_pkg;

    localparam int MAX_QUERY_LEN = 32;
    localparam int MAX_DEPTH     = 32;

    // column index 0..MAX_QUERY_LEN, query position, row index
    localparam int CW  = $clog2(MAX_QUERY_LEN + 1);
    localparam int QW  = $clog2(MAX_QUERY_LEN);
    localparam int DW  = $clog2(MAX_DEPTH);
    localparam int VW  = 7;
    localparam int CHW = 21;

    localparam logic [VW-1:0] ROW_MAX = 7'd127;

    // request kinds carried on tuser
    localparam logic CMD_LOAD_CHAR = 1'b0;
    localparam logic CMD_NODE_STEP = 1'b1;

    // configuration register indexes
    localparam logic [1:0] REG_QUERY_LENGTH   = 2'd0;
    localparam logic [1:0] REG_ALGORITHM_MODE = 2'd1;
    localparam logic [1:0] REG_CASE_SENSITIVE = 2'd2;

    // one column update, from the top level to the column unit
    typedef struct packed {
        logic           first;
        logic           tr_ok;
        logic           exact;
        logic [CHW-1:0] ch;
        logic [CHW-1:0] qc;
        logic [CHW-1:0] q1;
        logic [CHW-1:0] key;
        logic [VW-1:0]  left;
        logic [VW-1:0]  pv;
        logic [VW-1:0]  pdiag;
        logic [VW-1:0]  pp;
    } t_col_in;

    function automatic logic [CHW-1:0] fold(input logic [CHW-1:0] c, input logic exact);
        logic [CHW-1:0] r;
        r = c;
        if (!exact && c >= 21'h41 && c <= 21'h5A) begin
            r = c + 21'h20;
        end
        return r;
    endfunction

    function automatic logic [VW-1:0] sat_inc(input logic [VW-1:0] v);
        return (v >= ROW_MAX) ? ROW_MAX : v + 7'd1;
    endfunction

    // root row value at a column, held to the row range
    function automatic logic [VW-1:0] root_val(input logic [CW-1:0] k);
        return (32'(k) > 32'(ROW_MAX)) ? ROW_MAX : VW'(k);
    endfunction

endpackage

`default_nettype wire

[rtl/core/trie_edit_distance_rows.sv]
`default_nettype none

// channel   dir  bits  contents (lowest bit up)
// s (in)    in   48    tdata: query_pos[4:0] char_value[25:5] depth[31:26] entry_id[47:32]
//                      tuser: cmd, tlast: report
// m (out)   out  24    tdata: word_id[15:0] distance[22:16], zero pad
// cfg       in   6     write: 0 query_length, 1 algorithm_mode, 2 case_sensitive
//
// a query character load is taken while idle; a node step updates columns 0..query_length
// (query_length held to 32), one column per cycle through the row
// memory read, update, write loop
// a report passes through the result state to park the result in the output register
// synchronous active-low reset clears control only; memories need no clearing pass
// input is accepted only while idle; a stalled output holds the block in its
// result state until the previous result has been taken

module trie_edit_distance_rows (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_s_tvalid,
    output logic        o_s_tready,
    input  wire  [47:0] i_s_tdata,   // query_pos, char_value, depth, entry_id
    input  wire         i_s_tuser,   // cmd
    input  wire         i_s_tlast,   // report
    output logic        o_m_tvalid,
    input  wire         i_m_tready,
    output logic [23:0] o_m_tdata,   // word_id, distance
    input  wire         i_cfg_we,
    input  wire  [1:0]  i_cfg_addr,
    input  wire  [5:0]  i_cfg_wdata
);
    import ted_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_OUT
    } t_state;

    // request fields
    logic [4:0]     in_pos;
    logic [CHW-1:0] in_ch;
    logic [5:0]     in_depth;
    logic [15:0]    in_id;
    logic           in_take;
    logic           depth_ok;

    assign in_pos   = i_s_tdata[4:0];
    assign in_ch    = i_s_tdata[25:5];
    assign in_depth = i_s_tdata[31:26];
    assign in_id    = i_s_tdata[47:32];
    assign in_take  = i_s_tvalid && o_s_tready;
    assign depth_ok = (in_depth != 6'd0) && (32'(in_depth) <= MAX_DEPTH);

    // configuration registers
    logic [5:0] r_qlen_cfg;
    logic       r_mode;
    logic       r_exact;
    logic [CW-1:0] qlen;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qlen_cfg <= 6'd0;
            r_mode     <= 1'b0;
            r_exact    <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                REG_QUERY_LENGTH:   r_qlen_cfg <= i_cfg_wdata;
                REG_ALGORITHM_MODE: r_mode     <= i_cfg_wdata[0];
                REG_CASE_SENSITIVE: r_exact    <= i_cfg_wdata[0];
                default:   ;
            endcase
        end
    end

    assign qlen = (32'(r_qlen_cfg) > MAX_QUERY_LEN) ? CW'(MAX_QUERY_LEN) : CW'(r_qlen_cfg);

    // sequencer state
    t_state         r_state;
    logic           r_iss;        // column reads still being issued
    logic [CW-1:0]  r_ki;         // column being read
    logic           r_cv;         // read data valid for column r_kc
    logic [CW-1:0]  r_kc;         // column being updated
    logic [DW-1:0]  r_row;        // row store index of this depth
    logic           r_prev_root;  // parent is the root
    logic           r_pp_root;    // grandparent is the root
    logic           r_tr_en;
    logic [CHW-1:0] r_ch;
    logic           r_rep;
    logic [15:0]    r_id;
    logic [VW-1:0]  r_left;
    logic [VW-1:0]  r_pdiag;
    logic [CHW-1:0] r_q1;
    logic [VW-1:0]  r_res;
    logic           r_out_valid;
    logic [15:0]    r_out_id;
    logic [VW-1:0]  r_out_dist;

    // memories
    logic [CHW-1:0] qmem [MAX_QUERY_LEN];
    logic [CHW-1:0] kmem [MAX_DEPTH];
    logic [VW-1:0]  rmem [MAX_DEPTH << CW];
    logic [CHW-1:0] r_q_rd;
    logic [CHW-1:0] r_key_rd;
    logic [VW-1:0]  r_prev_rd;
    logic [VW-1:0]  r_pp_rd;

    logic [DW-1:0]  prev_row;
    logic [DW-1:0]  pp_row;
    logic [CW-1:0]  pp_col;
    logic           col_we;
    logic           last_col;
    logic [VW-1:0]  pv;
    logic [VW-1:0]  pp;
    t_col_in        col;
    logic [VW-1:0]  col_val;

    assign prev_row = r_row - DW'(1);
    assign pp_row   = r_row - DW'(2);
    assign pp_col   = r_ki - CW'(2);
    assign col_we   = (r_state == S_RUN) && r_cv;
    assign last_col = col_we && (r_kc == qlen);

    // query characters: loaded by requests, read one column ahead
    always_ff @(posedge i_clk) begin
        if (in_take && i_s_tuser == CMD_LOAD_CHAR && 32'(in_pos) < MAX_QUERY_LEN) begin
            qmem[QW'(in_pos)] <= in_ch;
        end
        r_q_rd <= qmem[QW'(r_ki - CW'(1))];
    end

    // node keys: parent key read at accept, own key written at the last column
    always_ff @(posedge i_clk) begin
        if (last_col) begin
            kmem[r_row] <= r_ch;
        end
        if (in_take) begin
            r_key_rd <= kmem[DW'(in_depth - 6'd2)];
        end
    end

    // row store: two reads (parent, grandparent) and one write (this row) per cycle
    always_ff @(posedge i_clk) begin
        if (col_we) begin
            rmem[{r_row, r_kc}] <= col_val;
        end
        r_prev_rd <= rmem[{prev_row, r_ki}];
        r_pp_rd   <= rmem[{pp_row, pp_col}];
    end

    // column update from the read data and the previous column
    always_comb begin
        pv = r_prev_root ? root_val(r_kc) : r_prev_rd;
        pp = r_pp_root ? root_val(r_kc - CW'(2)) : r_pp_rd;
        col.first = (r_kc == CW'(0));
        col.tr_ok = r_tr_en && (32'(r_kc) >= 2);
        col.exact = r_exact;
        col.ch    = r_ch;
        col.qc    = r_q_rd;
        col.q1    = r_q1;
        col.key   = r_key_rd;
        col.left  = r_left;
        col.pv    = pv;
        col.pdiag = r_pdiag;
        col.pp    = pp;
    end

    ted_col u_col (
        .i_col (col),
        .o_val (col_val)
    );

    // sequencer and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_iss       <= 1'b0;
            r_cv        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // the result state reloads the output register itself
            if (r_out_valid && i_m_tready && r_state != S_OUT) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_take && i_s_tuser != CMD_LOAD_CHAR && depth_ok) begin
                        r_state <= S_RUN;
                        r_iss   <= 1'b1;
                        r_cv    <= 1'b0;
                    end
                end
                S_RUN: begin
                    if (r_iss) begin
                        r_kc <= r_ki;
                        r_cv <= 1'b1;
                        if (r_ki == qlen) begin
                            r_iss <= 1'b0;
                        end else begin
                            r_ki <= r_ki + CW'(1);
                        end
                    end else begin
                        r_cv <= 1'b0;
                    end
                    if (col_we) begin
                        r_left  <= col_val;
                        r_pdiag <= pv;
                        r_q1    <= r_q_rd;
                    end
                    if (last_col) begin
                        r_res   <= col_val;
                        r_state <= r_rep ? S_OUT : S_IDLE;
                    end
                end
                S_OUT: begin
                    if (!r_out_valid || i_m_tready) begin
                        r_out_valid <= 1'b1;
                        r_out_id    <= r_id;
                        r_out_dist  <= r_res;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
            // step parameters latched at accept
            if (in_take) begin
                r_ki        <= CW'(0);
                r_row       <= DW'(in_depth - 6'd1);
                r_prev_root <= (in_depth == 6'd1);
                r_pp_root   <= (in_depth == 6'd2);
                r_tr_en     <= r_mode && (in_depth >= 6'd2);
                r_ch        <= in_ch;
                r_rep       <= i_s_tlast;
                r_id        <= in_id;
            end
        end
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {1'b0, r_out_dist, r_out_id};

endmodule

`default_nettype wire

[rtl/core/ted_col.sv]
`default_nettype none

module ted_col (
    input  var ted_pkg::t_col_in            i_col,
    output logic [ted_pkg::VW-1:0]           o_val
);
    import ted_pkg::*;

    logic [VW-1:0] a;
    logic [VW-1:0] b;
    logic [VW-1:0] c;
    logic [VW-1:0] t;
    logic [VW-1:0] m;
    logic          eq_q;
    logic          eq_key;
    logic          eq_ch1;
    logic          eq_qq;

    always_comb begin
        a      = sat_inc(i_col.left);
        b      = sat_inc(i_col.pv);
        c      = sat_inc(i_col.pdiag);
        t      = sat_inc(i_col.pp);
        eq_q   = fold(i_col.ch, i_col.exact) == fold(i_col.qc, i_col.exact);
        eq_key = fold(i_col.key, i_col.exact) == fold(i_col.qc, i_col.exact);
        eq_ch1 = fold(i_col.ch, i_col.exact) == fold(i_col.q1, i_col.exact);
        eq_qq  = fold(i_col.q1, i_col.exact) == fold(i_col.qc, i_col.exact);

        // substitution, insertion, deletion
        m = (a < b) ? a : b;
        if (c < m) begin
            m = c;
        end

        if (i_col.first) begin
            o_val = b;
        end else if (eq_q) begin
            o_val = i_col.pdiag;
        end else begin
            o_val = m;
        end

        // adjacent transposition
        if (i_col.tr_ok && eq_key && eq_ch1 && !eq_qq && t < o_val) begin
            o_val = t;
        end
    end

endmodule

`default_nettype wire
